// ===== sv/yc2rgb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yc2rgb_pkg: shared types and constants
// Payload structs, fixed-point BT.601 coefficients and the reciprocal used to
// divide by the coefficient scale of 10000.
// ----------------------------------------------------------------------------
package yc2rgb_pkg;

    // Number of register stages from input to the output register.
    localparam int NUM_STAGES = 8;

    // Signed width of every intermediate sum (all stay within +/- 2^23).
    localparam int SUM_W = 24;

    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [1:0][7:0]         t_px8;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] blue_first;
        logic [7:0] green_first;
        logic [7:0] red_first;
        logic [7:0] blue_second;
        logic [7:0] green_second;
        logic [7:0] red_second;
        logic       frame_end_out;
    } t_out_item;

    // First-stage products are all below 2^23.
    localparam logic [22:0] COEF_CR = 23'd15938;
    localparam logic [22:0] COEF_CB = 23'd20238;
    localparam logic [22:0] COEF_Y  = 23'd11644;
    localparam logic [22:0] COEF_YG = 23'd19837;

    // Green correction products are below 2^21.
    localparam logic [20:0] COEF_RG = 21'd5094;
    localparam logic [20:0] COEF_BG = 21'd1942;

    localparam t_sum OFFS_R = 24'sd2221300;
    localparam t_sum OFFS_B = 24'sd2771300;
    localparam t_sum OFFS_G = 24'sd311710;

    // Sums at or above this value clamp to 255.
    localparam t_sum CLAMP_TOP = 24'sd2560000;

    // floor(s / 10000) == (s * DIV_RECIP) >> DIV_SHIFT for 0 <= s < 2^22.
    localparam int          DIV_IN_W   = 22;
    localparam int          DIV_RCP_W  = 21;
    localparam int          DIV_PROD_W = DIV_IN_W + DIV_RCP_W;
    localparam int          DIV_SHIFT  = 34;
    localparam logic [20:0] DIV_RECIP  = 21'd1717987;

endpackage
`default_nettype wire

// ===== sv/yc2rgb_div_clamp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yc2rgb_div_clamp: divide by 10000 and clamp to a byte
// Two stages: reciprocal multiply with range flags, then the clamp select.
// ----------------------------------------------------------------------------
module yc2rgb_div_clamp (
    input  logic              i_clk,
    input  logic [1:0]        i_en,
    input  yc2rgb_pkg::t_sum  i_sum,
    output logic [7:0]        o_byte
);
    import yc2rgb_pkg::*;

    logic [DIV_PROD_W-1:0] w_prod;
    logic [7:0]            r_q, n_q;
    logic                  r_lo, n_lo;
    logic                  r_hi, n_hi;
    logic [7:0]            r_byte, n_byte;

    // Only sums inside 0..2559999 use the quotient, and those fit in 22 bits.
    always_comb begin
        w_prod = DIV_PROD_W'(i_sum[DIV_IN_W-1:0]) * DIV_PROD_W'(DIV_RECIP);
        n_q    = w_prod[DIV_SHIFT+7:DIV_SHIFT];
        n_lo   = i_sum[SUM_W-1];
        n_hi   = (i_sum >= CLAMP_TOP);
    end

    always_comb begin
        if (r_lo) begin
            n_byte = 8'd0;
        end else if (r_hi) begin
            n_byte = 8'd255;
        end else begin
            n_byte = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_q  <= n_q;
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (i_en[1]) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule
`default_nettype wire

// ===== sv/yc2rgb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yc2rgb_front: coefficient products and red/blue sums
// Stage one forms the constant products, stage two the offset sums for
// red, blue and the luma part of green for both pixels.
// ----------------------------------------------------------------------------
module yc2rgb_front (
    input  logic                    i_clk,
    input  logic [1:0]              i_en,
    input  yc2rgb_pkg::t_in_item    i_data,
    output yc2rgb_pkg::t_sum [1:0]  o_sum_r,
    output yc2rgb_pkg::t_sum [1:0]  o_sum_b,
    output yc2rgb_pkg::t_sum [1:0]  o_gy
);
    import yc2rgb_pkg::*;

    logic [22:0]       r_p_cr, n_p_cr;
    logic [22:0]       r_p_cb, n_p_cb;
    logic [1:0][22:0]  r_p_y, n_p_y;
    logic [1:0][22:0]  r_p_yg, n_p_yg;
    t_sum [1:0]        r_sum_r, n_sum_r;
    t_sum [1:0]        r_sum_b, n_sum_b;
    t_sum [1:0]        r_gy, n_gy;
    logic [1:0][7:0]   w_luma;

    assign w_luma = {i_data.luma_second, i_data.luma_first};

    always_comb begin
        n_p_cr = 23'(i_data.chroma_red) * COEF_CR;
        n_p_cb = 23'(i_data.chroma_blue) * COEF_CB;
        for (int p = 0; p < 2; p++) begin
            n_p_y[p]  = 23'(w_luma[p]) * COEF_Y;
            n_p_yg[p] = 23'(w_luma[p]) * COEF_YG;
        end
    end

    always_comb begin
        for (int p = 0; p < 2; p++) begin
            n_sum_r[p] = $signed({1'b0, r_p_cr}) + $signed({1'b0, r_p_y[p]}) - OFFS_R;
            n_sum_b[p] = $signed({1'b0, r_p_cb}) + $signed({1'b0, r_p_y[p]}) - OFFS_B;
            n_gy[p]    = $signed({1'b0, r_p_yg[p]}) - OFFS_G;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p_cr <= n_p_cr;
            r_p_cb <= n_p_cb;
            r_p_y  <= n_p_y;
            r_p_yg <= n_p_yg;
        end
        if (i_en[1]) begin
            r_sum_r <= n_sum_r;
            r_sum_b <= n_sum_b;
            r_gy    <= n_gy;
        end
    end

    assign o_sum_r = r_sum_r;
    assign o_sum_b = r_sum_b;
    assign o_gy    = r_gy;

endmodule
`default_nettype wire

// ===== sv/yc2rgb_green.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// yc2rgb_green: green sum from luma and the clamped red and blue
// Stage one forms the red and blue correction products, stage two the sum.
// ----------------------------------------------------------------------------
module yc2rgb_green (
    input  logic              i_clk,
    input  logic [1:0]        i_en,
    input  yc2rgb_pkg::t_sum  i_gy,
    input  logic [7:0]        i_red,
    input  logic [7:0]        i_blue,
    output yc2rgb_pkg::t_sum  o_sum
);
    import yc2rgb_pkg::*;

    logic [20:0] r_pr, n_pr;
    logic [20:0] r_pb, n_pb;
    t_sum        r_gy;
    t_sum        r_sum, n_sum;

    always_comb begin
        n_pr  = 21'(i_red) * COEF_RG;
        n_pb  = 21'(i_blue) * COEF_BG;
        n_sum = r_gy - $signed({3'b000, r_pr}) - $signed({3'b000, r_pb});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pr <= n_pr;
            r_pb <= n_pb;
            r_gy <= i_gy;
        end
        if (i_en[1]) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule
`default_nettype wire

// ===== sv/ycbcr422_pair_to_rgb888.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ycbcr422_pair_to_rgb888: 4:2:2 pixel pair to two RGB888 pixels
// BT.601 studio-range conversion in an eight-stage pipeline.
// ----------------------------------------------------------------------------
// The block takes one pixel pair per clock while the output is not stalled
// and returns its two RGB888 pixels in order. Red and blue come from the luma
// and the shared chroma bytes; green is then formed from the luma and the
// already clamped red and blue. Every sum is divided by 10000 with truncation
// toward zero and clamped to 0..255, using a reciprocal multiply that is exact
// over the range that survives the clamp. The end-of-frame flag travels
// alongside the pixel data unchanged. Each of the eight stages carries its own
// valid bit and advances whenever the stage after it is empty or moving, so
// bubbles close up and o_ready drops only when all eight stages hold a pair
// and the output transfer is stalled. The sustained rate is one transfer per
// clock in both directions while the receiver does not stall. The eight
// register stages are products, red/blue sums, divide multiply, clamp, green
// products, green sum, divide multiply and clamp into the output register.
// ----------------------------------------------------------------------------
module ycbcr422_pair_to_rgb888 (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  yc2rgb_pkg::t_in_item   i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output yc2rgb_pkg::t_out_item  o_data
);
    import yc2rgb_pkg::*;

    // Per-stage valid bits and load enables. A stage loads when it is empty
    // or when the stage after it loads in the same cycle.
    logic [NUM_STAGES-1:0] r_vld, n_vld;
    logic [NUM_STAGES-1:0] w_rdy;

    // End-of-frame flag, one bit per stage.
    logic [NUM_STAGES-1:0] r_fe, n_fe;

    // Luma part of green, carried while red and blue are divided.
    t_sum [1:0] r_gy2, r_gy3;

    // Clamped red and blue, carried while green is computed.
    t_px8 r_red_c  [4];
    t_px8 r_blue_c [4];

    t_sum [1:0] w_sum_r;
    t_sum [1:0] w_sum_b;
    t_sum [1:0] w_gy;
    t_sum [1:0] w_sum_g;
    t_px8       w_red;
    t_px8       w_blue;
    t_px8       w_green;

    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        n_vld = {r_vld[NUM_STAGES-2:0], i_valid};
        n_fe  = {r_fe[NUM_STAGES-2:0], i_data.frame_end};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (w_rdy[k]) begin
                r_fe[k] <= n_fe[k];
            end
        end
        if (w_rdy[2]) begin
            r_gy2 <= w_gy;
        end
        if (w_rdy[3]) begin
            r_gy3 <= r_gy2;
        end
        if (w_rdy[4]) begin
            r_red_c[0]  <= w_red;
            r_blue_c[0] <= w_blue;
        end
        for (int k = 1; k < 4; k++) begin
            if (w_rdy[4+k]) begin
                r_red_c[k]  <= r_red_c[k-1];
                r_blue_c[k] <= r_blue_c[k-1];
            end
        end
    end

    // Stages one and two: products and red/blue sums.
    yc2rgb_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_rdy[1:0]),
        .i_data  (i_data),
        .o_sum_r (w_sum_r),
        .o_sum_b (w_sum_b),
        .o_gy    (w_gy)
    );

    for (genvar p = 0; p < 2; p++) begin : g_pixel
        // Stages three and four: red and blue divide and clamp.
        yc2rgb_div_clamp u_div_r (
            .i_clk  (i_clk),
            .i_en   (w_rdy[3:2]),
            .i_sum  (w_sum_r[p]),
            .o_byte (w_red[p])
        );

        yc2rgb_div_clamp u_div_b (
            .i_clk  (i_clk),
            .i_en   (w_rdy[3:2]),
            .i_sum  (w_sum_b[p]),
            .o_byte (w_blue[p])
        );

        // Stages five and six: green sum from the clamped red and blue.
        yc2rgb_green u_green (
            .i_clk  (i_clk),
            .i_en   (w_rdy[5:4]),
            .i_gy   (r_gy3[p]),
            .i_red  (w_red[p]),
            .i_blue (w_blue[p]),
            .o_sum  (w_sum_g[p])
        );

        // Stages seven and eight: green divide and clamp into the output.
        yc2rgb_div_clamp u_div_g (
            .i_clk  (i_clk),
            .i_en   (w_rdy[7:6]),
            .i_sum  (w_sum_g[p]),
            .o_byte (w_green[p])
        );
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    always_comb begin
        o_data.blue_first    = r_blue_c[3][0];
        o_data.green_first   = w_green[0];
        o_data.red_first     = r_red_c[3][0];
        o_data.blue_second   = r_blue_c[3][1];
        o_data.green_second  = w_green[1];
        o_data.red_second    = r_red_c[3][1];
        o_data.frame_end_out = r_fe[NUM_STAGES-1];
    end

    // The pipeline is empty after reset.
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // The input side only stalls when every stage holds a pair.
    a_full_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // A stalled red/blue clamp stage keeps its item and its bytes.
    a_rb_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] && !w_rdy[4] |=> r_vld[3] && $stable(w_red) && $stable(w_blue))
        else $error("red/blue stage changed while stalled");

endmodule
`default_nettype wire

// ===== tb/ycbcr422_pair_to_rgb888_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr422_pair_to_rgb888_checker: scoreboard for the pixel pair converter
// Watches both channels, computes the expected RGB888 pair for every input
// transfer and compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module ycbcr422_pair_to_rgb888_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  yc2rgb_pkg::t_in_item   i_in_data,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  yc2rgb_pkg::t_out_item  i_out_data,
    output int                     o_fail_count,
    output int                     o_pending_count
);
    import yc2rgb_pkg::*;

    // BT.601 studio-range coefficients, all scaled by 10000.
    localparam int K_RED_CR   = 15938;
    localparam int K_RED_OFS  = 2221300;
    localparam int K_BLUE_CB  = 20238;
    localparam int K_BLUE_OFS = 2771300;
    localparam int K_LUMA     = 11644;
    localparam int K_GRN_Y    = 19837;
    localparam int K_GRN_OFS  = 311710;
    localparam int K_GRN_R    = 5094;
    localparam int K_GRN_B    = 1942;
    localparam int K_SCALE    = 10000;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_bgr;

    t_out_item expected_pairs[$];
    int        mismatches = 0;

    assign o_fail_count    = mismatches;
    assign o_pending_count = expected_pairs.size();

    // Integer division in SystemVerilog truncates toward zero, as required.
    function automatic logic [7:0] descale_clamp(int sum);
        int q;
        q = sum / K_SCALE;
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    // Green is formed from the already clamped red and blue.
    function automatic t_bgr pixel_to_bgr(int y, int cb, int cr);
        t_bgr px;
        px.red   = descale_clamp(K_RED_CR * cr - K_RED_OFS + K_LUMA * y);
        px.blue  = descale_clamp(K_BLUE_CB * cb - K_BLUE_OFS + K_LUMA * y);
        px.green = descale_clamp(K_GRN_Y * y - K_GRN_OFS
                                 - K_GRN_R * int'(px.red) - K_GRN_B * int'(px.blue));
        return px;
    endfunction

    function automatic t_out_item convert_pair(t_in_item pair);
        t_out_item rgb;
        t_bgr      px0;
        t_bgr      px1;
        px0 = pixel_to_bgr(int'(pair.luma_first), int'(pair.chroma_blue),
                           int'(pair.chroma_red));
        px1 = pixel_to_bgr(int'(pair.luma_second), int'(pair.chroma_blue),
                           int'(pair.chroma_red));
        rgb.blue_first    = px0.blue;
        rgb.green_first   = px0.green;
        rgb.red_first     = px0.red;
        rgb.blue_second   = px1.blue;
        rgb.green_second  = px1.green;
        rgb.red_second    = px1.red;
        rgb.frame_end_out = pair.frame_end;
        return rgb;
    endfunction

    task automatic compare_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                expected_pairs.push_back(convert_pair(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_pairs.size() == 0) begin
                    $error("output transfer with no pixel pair outstanding");
                    mismatches++;
                end else begin
                    want = expected_pairs.pop_front();
                    compare_field("blue_first", want.blue_first, i_out_data.blue_first);
                    compare_field("green_first", want.green_first, i_out_data.green_first);
                    compare_field("red_first", want.red_first, i_out_data.red_first);
                    compare_field("blue_second", want.blue_second, i_out_data.blue_second);
                    compare_field("green_second", want.green_second,
                                  i_out_data.green_second);
                    compare_field("red_second", want.red_second, i_out_data.red_second);
                    compare_field("frame_end_out", {7'd0, want.frame_end_out},
                                  {7'd0, i_out_data.frame_end_out});
                end
            end
        end
    end

endmodule

// ===== tb/tb_ycbcr422_pair_to_rgb888.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ycbcr422_pair_to_rgb888: testbench for the 4:2:2 pair to RGB888 converter
// Sends a directed set of corner pixel pairs followed by randomized pairs,
// with random gaps on the input side and random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_ycbcr422_pair_to_rgb888;
    import yc2rgb_pkg::*;

    // Cycles with no transfer on either channel before the run is abandoned.
    // The longest legal quiet stretch is a long sender gap or a long receiver
    // stall plus the pipeline depth, so this leaves a wide margin.
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_PAIRS = 1030;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_data  = '0;
    logic      i_ready = 1'b0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_data;

    // When set, neither side inserts idle cycles, so the pipeline runs full.
    logic steady = 1'b0;

    int fail_count;
    int pending_count;

    ycbcr422_pair_to_rgb888 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    ycbcr422_pair_to_rgb888_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_in_data       (i_data),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_out_data      (o_data),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Idle lengths are mostly zero or short, with an occasional long one so
    // that the pipeline both drains completely and fills up behind a stall.
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // A quarter of the random bytes come from the values where the clamps and
    // the studio-range limits sit; the rest are uniform.
    function automatic logic [7:0] pick_byte();
        logic [7:0] corners[7];
        corners = '{8'd0, 8'd1, 8'd16, 8'd128, 8'd235, 8'd254, 8'd255};
        if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 6)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_in_item make_pair(logic [7:0] y0, logic [7:0] y1,
                                           logic [7:0] cb, logic [7:0] cr,
                                           logic fe);
        t_in_item pair;
        pair.luma_first  = y0;
        pair.luma_second = y1;
        pair.chroma_blue = cb;
        pair.chroma_red  = cr;
        pair.frame_end   = fe;
        return pair;
    endfunction

    // Presents one pixel pair and returns once its input transfer has taken
    // place. Valid drops only when a gap is inserted, and rises again at a
    // later falling edge, so it never gets two updates in one time step.
    task automatic send_pair(t_in_item pair);
        int gap;
        gap = steady ? 0 : pick_idle();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= pair;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
    endtask

    // Directed corners: black and white, every chroma extreme against both
    // luma extremes, studio-range limits, and pairs whose two lumas differ so
    // that a swap between the pixels shows up. Negative sums that must clamp
    // to zero and sums beyond 255 that must clamp high are both covered.
    task automatic send_corner_pairs();
        logic [7:0] ends[2];
        ends = '{8'd0, 8'd255};
        send_pair(make_pair(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_pair(make_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        send_pair(make_pair(8'd0, 8'd255, 8'd128, 8'd128, 1'b0));
        send_pair(make_pair(8'd255, 8'd0, 8'd128, 8'd128, 1'b0));
        send_pair(make_pair(8'd16, 8'd235, 8'd128, 8'd128, 1'b0));
        send_pair(make_pair(8'd235, 8'd16, 8'd128, 8'd128, 1'b1));
        foreach (ends[b]) begin
            foreach (ends[r]) begin
                foreach (ends[y]) begin
                    send_pair(make_pair(ends[y], ends[1 - y], ends[b], ends[r],
                                        1'(y)));
                end
            end
        end
        send_pair(make_pair(8'd128, 8'd128, 8'd16, 8'd240, 1'b0));
        send_pair(make_pair(8'd128, 8'd128, 8'd240, 8'd16, 1'b0));
        send_pair(make_pair(8'd81, 8'd145, 8'd90, 8'd240, 1'b0));
        send_pair(make_pair(8'd1, 8'd254, 8'd1, 8'd254, 1'b1));
        send_pair(make_pair(8'd254, 8'd1, 8'd254, 8'd1, 1'b0));
        send_pair(make_pair(8'd170, 8'd85, 8'd170, 8'd85, 1'b0));
        send_pair(make_pair(8'd85, 8'd170, 8'd85, 8'd170, 1'b1));
    endtask

    // Output side: alternating runs of ready and stall, one update per
    // falling edge. During steady stretches the receiver never stalls.
    initial begin : sink_pacing
        int  run;
        logic accept;
        run    = 0;
        accept = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (steady) begin
                accept = 1'b1;
                run    = 0;
            end else if (run == 0) begin
                accept = !accept;
                run    = accept ? $urandom_range(1, 12) : 1 + pick_idle();
            end else begin
                run--;
            end
            i_ready <= accept;
        end
    end

    // Watchdog: counts clock cycles in which no transfer happens on either
    // channel and abandons the run once the count reaches the limit.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        t_in_item pair;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_corner_pairs();

        // Random pairs in blocks; every third block runs without idling on
        // either side so the pipeline stays full for a while.
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            steady = ((n / 128) % 3) == 2;
            pair = make_pair(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                             $urandom_range(0, 7) == 0);
            send_pair(pair);
        end
        steady = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Let every outstanding pair come out, then give the pipeline time to
        // show any stray extra transfer.
        while (pending_count != 0) @(posedge i_clk);
        repeat (2 * NUM_STAGES + 4) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
